/* rtl/core/spa_pkg.sv */
// Shared types, constants and the control program of the slot pool allocator.
`timescale 1ns / 1ps

package spa_pkg;

  // Pool geometry. A link holds a slot number or the null code, which equals SLOTS.
  localparam int unsigned SLOTS = 64;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LNK_W = $clog2(SLOTS + 1);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [LNK_W-1:0] NIL = LNK_W'(SLOTS);

  // Field widths of the stream payload and of the step counter.
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned UCNT_W  = 7;
  localparam int unsigned STEP_W  = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  // Datapath operation of one step.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_AL_LINK,
    OP_AL_PUSH,
    OP_RL_UNLINK,
    OP_RL_PUSH
  } op_e;

  // Jump condition of one step.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_DISPATCH,
    JC_FREE_NIL,
    JC_NOT_USED,
    JC_OUT
  } jc_e;

  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_A0   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_A1   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_A2   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_R0   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_R1   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_R2   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DONE = 3'd7;

  typedef struct packed {
    logic              in_rdy;
    logic              rd_en;
    logic              rd_free;
    op_e               op;
    logic              out_load;
    jc_e               jc;
    logic [STEP_W-1:0] tgt;
  } ctl_t;

  typedef struct packed {
    logic acc;
    logic rel;
    logic free_nil;
    logic not_used;
    logic out_free;
  } cond_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [LNK_W-1:0] data;
  } lnk_wr_t;

  function automatic logic lnk_ok(input logic [LNK_W-1:0] x);
    return x < NIL;
  endfunction

  // Control store: one word per step.
  function automatic ctl_t ucode(input logic [STEP_W-1:0] pc);
    ctl_t w;
    w = '{in_rdy: 1'b0, rd_en: 1'b0, rd_free: 1'b0, op: OP_NONE, out_load: 1'b0,
          jc: JC_NEXT, tgt: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.jc     = JC_DISPATCH;
        w.tgt    = STEP_R0;
      end
      STEP_A0: begin
        w.rd_en   = 1'b1;
        w.rd_free = 1'b1;
        w.jc      = JC_FREE_NIL;
        w.tgt     = STEP_DONE;
      end
      STEP_A1: begin
        w.op = OP_AL_LINK;
      end
      STEP_A2: begin
        w.op  = OP_AL_PUSH;
        w.jc  = JC_ALWAYS;
        w.tgt = STEP_DONE;
      end
      STEP_R0: begin
        w.rd_en = 1'b1;
        w.jc    = JC_NOT_USED;
        w.tgt   = STEP_DONE;
      end
      STEP_R1: begin
        w.op = OP_RL_UNLINK;
      end
      STEP_R2: begin
        w.op = OP_RL_PUSH;
      end
      STEP_DONE: begin
        w.out_load = 1'b1;
        w.jc       = JC_OUT;
        w.tgt      = STEP_IDLE;
      end
      default: begin
        w.jc  = JC_ALWAYS;
        w.tgt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/spa_link_mem.sv */
// Forward and backward link memories of the slot pool, with registered reads.
`timescale 1ns / 1ps

module spa_link_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [spa_pkg::IDX_W-1:0]   rd_addr_i,
  input  spa_pkg::lnk_wr_t            nxt_wr_i,
  input  spa_pkg::lnk_wr_t            prv_wr_i,
  output logic [spa_pkg::LNK_W-1:0]   nxt_rdata_o,
  output logic [spa_pkg::LNK_W-1:0]   prv_rdata_o
);

  logic [spa_pkg::LNK_W-1:0] nxt_mem [spa_pkg::SLOTS];
  logic [spa_pkg::LNK_W-1:0] prv_mem [spa_pkg::SLOTS];
  logic [spa_pkg::SLOTS-1:0] nxt_vld_q;

  logic [spa_pkg::LNK_W-1:0] nxt_rd_q;
  logic [spa_pkg::LNK_W-1:0] prv_rd_q;
  logic                      nxt_rv_q;
  logic [spa_pkg::IDX_W-1:0] rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (nxt_wr_i.we) begin
      nxt_mem[nxt_wr_i.addr] <= nxt_wr_i.data;
    end
    if (prv_wr_i.we) begin
      prv_mem[prv_wr_i.addr] <= prv_wr_i.data;
    end
    if (rd_en_i) begin
      nxt_rd_q <= nxt_mem[rd_addr_i];
      prv_rd_q <= prv_mem[rd_addr_i];
      rd_idx_q <= rd_addr_i;
    end
  end

  // A forward link never written still holds its reset threading: the next index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_vld_q <= '0;
      nxt_rv_q  <= 1'b0;
    end else begin
      if (nxt_wr_i.we) begin
        nxt_vld_q[nxt_wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        nxt_rv_q <= nxt_vld_q[rd_addr_i];
      end
    end
  end

  assign nxt_rdata_o = nxt_rv_q ? nxt_rd_q
                                : spa_pkg::LNK_W'(rd_idx_q) + spa_pkg::LNK_W'(1);
  assign prv_rdata_o = prv_rd_q;

endmodule

/* rtl/core/spa_sequencer.sv */
// Step counter and jump logic that walks the allocator's control program.
`timescale 1ns / 1ps

module spa_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spa_pkg::cond_t cond_i,
  output spa_pkg::ctl_t  ctl_o,
  output logic          jmp_o
);

  logic [spa_pkg::STEP_W-1:0] pc_q;
  logic [spa_pkg::STEP_W-1:0] pc_d;
  spa_pkg::ctl_t              ctl;

  assign ctl = spa_pkg::ucode(pc_q);

  always_comb begin
    pc_d  = pc_q + spa_pkg::STEP_W'(1);
    jmp_o = 1'b0;
    case (ctl.jc)
      spa_pkg::JC_NEXT: begin
        jmp_o = 1'b0;
      end
      spa_pkg::JC_ALWAYS: begin
        jmp_o = 1'b1;
      end
      spa_pkg::JC_DISPATCH: begin
        if (!cond_i.acc) begin
          pc_d = pc_q;
        end else begin
          jmp_o = cond_i.rel;
        end
      end
      spa_pkg::JC_FREE_NIL: begin
        jmp_o = cond_i.free_nil;
      end
      spa_pkg::JC_NOT_USED: begin
        jmp_o = cond_i.not_used;
      end
      spa_pkg::JC_OUT: begin
        if (cond_i.out_free) begin
          jmp_o = 1'b1;
        end else begin
          pc_d = pc_q;
        end
      end
      default: begin
        jmp_o = 1'b1;
      end
    endcase
    if (jmp_o) begin
      pc_d = ctl.tgt;
    end
  end

  always_comb begin
    ctl_o = ctl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= spa_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/core/slot_pool_allocator_unit.sv */
// Top level of the slot pool allocator: list heads, slot flags, count and output register.
`timescale 1ns / 1ps

// The block hands out and takes back slots of a fixed pool of 64.
// Requests arrive on the s_axis channel: tuser carries the request type (0 allocate,
// 1 release) and tdata the slot to release. Each request produces exactly one
// result on the m_axis channel with the slot granted or released, a status code
// (ok, pool empty, or release of a slot that is not allocated) and the number of
// allocated slots after the request.
// A small control program steps through each request: an allocate runs the steps
// A0, A1, A2 and DONE, a release the steps R0, R1, R2 and DONE, and a rejected
// request jumps from A0 or R0 straight to DONE, where the result is loaded.
// The step count is set by the single write port on each link memory: a release must
// patch both neighbors and then relink the slot itself.
// After reset the free list holds all slots in index order, slot 0 first, and no
// slot is allocated; no clearing pass is needed.
// The result waits in an output register. If the receiver stalls, the program
// holds in its final step until the register frees, and no new request is taken
// until then; nothing is lost or repeated.

module slot_pool_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [5:0] slot_index, [7:6] zero
  input  logic        s_axis_tuser_i,   // [0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [5:0] slot_out, [12:6] used_count, [15:13] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  spa_pkg::ctl_t    ctl;
  spa_pkg::cond_t   cond;
  logic             jmp;
  logic             acc;

  // Pool state.
  logic [spa_pkg::LNK_W-1:0] free_head_q, free_head_d;
  logic [spa_pkg::LNK_W-1:0] used_head_q, used_head_d;
  logic [spa_pkg::CNT_W-1:0] count_q, count_d;
  logic [spa_pkg::SLOTS-1:0] in_use_q, in_use_d;

  // Working registers of the current request.
  logic [spa_pkg::LNK_W-1:0]  slot_q, slot_d;
  logic [spa_pkg::SLOT_W-1:0] res_slot_q, res_slot_d;
  logic                       rng_ok_q, rng_ok_d;
  spa_pkg::status_e           st_q, st_d;

  // Output register.
  logic                       m_vld_q, m_vld_d;
  logic [spa_pkg::SLOT_W-1:0] m_slot_q;
  logic [spa_pkg::UCNT_W-1:0] m_cnt_q;
  spa_pkg::status_e           m_st_q;

  // Link memories.
  logic [spa_pkg::IDX_W-1:0] rd_addr;
  spa_pkg::lnk_wr_t          nxt_wr;
  spa_pkg::lnk_wr_t          prv_wr;
  logic [spa_pkg::LNK_W-1:0] nxt_rdata;
  logic [spa_pkg::LNK_W-1:0] prv_rdata;

  logic [31:0] cnt_ext;
  logic        load;

  assign acc             = s_axis_tvalid_i && ctl.in_rdy;
  assign s_axis_tready_o = ctl.in_rdy;

  assign cond.acc      = acc;
  assign cond.rel      = s_axis_tuser_i;
  assign cond.free_nil = !spa_pkg::lnk_ok(free_head_q);
  assign cond.not_used = !rng_ok_q || !in_use_q[slot_q[spa_pkg::IDX_W-1:0]];
  assign cond.out_free = !m_vld_q || m_axis_tready_i;

  spa_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctl_o  (ctl),
    .jmp_o  (jmp)
  );

  assign rd_addr = ctl.rd_free ? free_head_q[spa_pkg::IDX_W-1:0]
                               : slot_q[spa_pkg::IDX_W-1:0];

  spa_link_mem u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (ctl.rd_en),
    .rd_addr_i   (rd_addr),
    .nxt_wr_i    (nxt_wr),
    .prv_wr_i    (prv_wr),
    .nxt_rdata_o (nxt_rdata),
    .prv_rdata_o (prv_rdata)
  );

  // Datapath: each step's operation decides the link writes and head updates.
  always_comb begin
    free_head_d = free_head_q;
    used_head_d = used_head_q;
    count_d     = count_q;
    in_use_d    = in_use_q;
    slot_d      = slot_q;
    res_slot_d  = res_slot_q;
    rng_ok_d    = rng_ok_q;
    st_d        = st_q;
    nxt_wr      = '{we: 1'b0, addr: slot_q[spa_pkg::IDX_W-1:0], data: used_head_q};
    prv_wr      = '{we: 1'b0, addr: slot_q[spa_pkg::IDX_W-1:0], data: spa_pkg::NIL};

    if (acc) begin
      slot_d     = spa_pkg::LNK_W'(s_axis_tdata_i[spa_pkg::SLOT_W-1:0]);
      res_slot_d = s_axis_tdata_i[spa_pkg::SLOT_W-1:0];
      rng_ok_d   = 32'(s_axis_tdata_i[spa_pkg::SLOT_W-1:0]) < spa_pkg::SLOTS;
      st_d       = spa_pkg::ST_OK;
    end

    // The allocate path takes the free head as its working slot.
    if (ctl.rd_en && ctl.rd_free) begin
      slot_d     = free_head_q;
      res_slot_d = spa_pkg::SLOT_W'(free_head_q);
    end

    if (jmp && ctl.jc == spa_pkg::JC_FREE_NIL) begin
      st_d       = spa_pkg::ST_EMPTY;
      res_slot_d = '0;
    end
    if (jmp && ctl.jc == spa_pkg::JC_NOT_USED) begin
      st_d = spa_pkg::ST_BAD;
    end

    case (ctl.op)
      spa_pkg::OP_NONE: begin
        nxt_wr.we = 1'b0;
      end
      spa_pkg::OP_AL_LINK: begin
        // Pop the free list and point the new slot at the old allocated head.
        free_head_d = nxt_rdata;
        nxt_wr.we   = 1'b1;
        nxt_wr.data = used_head_q;
        prv_wr.we   = 1'b1;
        prv_wr.data = spa_pkg::NIL;
      end
      spa_pkg::OP_AL_PUSH: begin
        // Back link of the old allocated head, then the new head.
        prv_wr.we   = spa_pkg::lnk_ok(used_head_q);
        prv_wr.addr = used_head_q[spa_pkg::IDX_W-1:0];
        prv_wr.data = slot_q;
        used_head_d = slot_q;
        in_use_d[slot_q[spa_pkg::IDX_W-1:0]] = 1'b1;
        count_d     = count_q + spa_pkg::CNT_W'(1);
      end
      spa_pkg::OP_RL_UNLINK: begin
        // Join the neighbors of the released slot around it.
        if (used_head_q == slot_q) begin
          used_head_d = nxt_rdata;
        end
        prv_wr.we   = spa_pkg::lnk_ok(nxt_rdata);
        prv_wr.addr = nxt_rdata[spa_pkg::IDX_W-1:0];
        prv_wr.data = prv_rdata;
        nxt_wr.we   = spa_pkg::lnk_ok(prv_rdata);
        nxt_wr.addr = prv_rdata[spa_pkg::IDX_W-1:0];
        nxt_wr.data = nxt_rdata;
      end
      spa_pkg::OP_RL_PUSH: begin
        // Push the released slot on the front of the free list.
        nxt_wr.we   = 1'b1;
        nxt_wr.data = free_head_q;
        prv_wr.we   = 1'b1;
        prv_wr.data = spa_pkg::NIL;
        free_head_d = slot_q;
        in_use_d[slot_q[spa_pkg::IDX_W-1:0]] = 1'b0;
        count_d     = count_q - spa_pkg::CNT_W'(1);
      end
      default: begin
        nxt_wr.we = 1'b0;
      end
    endcase
  end

  assign cnt_ext = 32'(count_q);
  assign load    = ctl.out_load && cond.out_free;

  always_comb begin
    m_vld_d = m_vld_q;
    if (m_axis_tready_i) begin
      m_vld_d = 1'b0;
    end
    if (load) begin
      m_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      used_head_q <= spa_pkg::NIL;
      count_q     <= '0;
      in_use_q    <= '0;
      m_vld_q     <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      used_head_q <= used_head_d;
      count_q     <= count_d;
      in_use_q    <= in_use_d;
      m_vld_q     <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    res_slot_q <= res_slot_d;
    rng_ok_q   <= rng_ok_d;
    st_q       <= st_d;
    if (load) begin
      m_slot_q <= res_slot_q;
      m_cnt_q  <= cnt_ext[spa_pkg::UCNT_W-1:0];
      m_st_q   <= st_q;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {3'b000, m_cnt_q, m_slot_q};
  assign m_axis_tuser_o  = m_st_q;

endmodule
